/* hw/rtl/anchored_literal_matcher_macros.svh */
// -----------------------------------------------------------------------------
// Anchored literal matcher assertion macros
// Shared assertion forms for the checker, clocked on i_clk with i_rst_n reset.
// -----------------------------------------------------------------------------
`ifndef ANCHORED_LITERAL_MATCHER_MACROS_SVH
`define ANCHORED_LITERAL_MATCHER_MACROS_SVH

// Same-cycle implication.
`define ALM_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define ALM_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

/* hw/rtl/alm_pkg.sv */
// -----------------------------------------------------------------------------
// Anchored literal matcher package
// Register indexes, widths, defaults and the case folding compare.
// -----------------------------------------------------------------------------
package alm_pkg;

    localparam int MAX_PATTERN_DEF = 32;
    localparam int MAX_SUBJECT_DEF = 65535;

    localparam int CFG_W    = 64;
    localparam int CFG_IDX_W = 3;
    localparam int PAT_REGS = 4;
    localparam int PAT_BYTES = 32;
    localparam int PIDX_W   = 5;
    localparam int PLEN_W   = 6;
    localparam int POS_W    = 16;
    localparam int WORK_W   = 17;

    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;

    localparam t_cfg_idx CFG_PAT0  = 3'd0;
    localparam t_cfg_idx CFG_PAT1  = 3'd1;
    localparam t_cfg_idx CFG_PAT2  = 3'd2;
    localparam t_cfg_idx CFG_PAT3  = 3'd3;
    localparam t_cfg_idx CFG_LEN   = 3'd4;
    localparam t_cfg_idx CFG_ANC_S = 3'd5;
    localparam t_cfg_idx CFG_ANC_E = 3'd6;
    localparam t_cfg_idx CFG_FOLD  = 3'd7;

    localparam logic [7:0] UPPER_A    = 8'h41;
    localparam logic [7:0] UPPER_Z    = 8'h5A;
    localparam logic [7:0] CASE_DELTA = 8'h20;

    typedef struct packed {
        logic shift;
        logic fold;
    } t_cell_ctl;

    function automatic logic [7:0] fold_byte(input logic [7:0] c, input logic en);
        if (en && c >= UPPER_A && c <= UPPER_Z) begin
            return c + CASE_DELTA;
        end
        return c;
    endfunction

    function automatic logic same_byte(input logic [7:0] a, input logic [7:0] b,
                                       input logic en);
        return fold_byte(a, en) == fold_byte(b, en);
    endfunction

endpackage

/* hw/rtl/alm_cell.sv */
// -----------------------------------------------------------------------------
// Window cell
// Holds one subject byte, passes it on when the window shifts, and compares
// the byte it will hold against its aligned pattern byte.
// -----------------------------------------------------------------------------
module alm_cell (
    input  logic               i_clk,
    input  alm_pkg::t_cell_ctl i_ctl,
    input  logic [7:0]         i_left,
    input  logic [7:0]         i_pat,
    input  logic               i_active,
    output logic [7:0]         o_data,
    output logic               o_ok
);

    logic [7:0] r_data;
    logic [7:0] n_data;

    always_comb begin
        n_data = i_ctl.shift ? i_left : r_data;
        o_ok   = !i_active || alm_pkg::same_byte(n_data, i_pat, i_ctl.fold);
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data = r_data;

endmodule

/* hw/rtl/anchored_literal_matcher.sv */
// -----------------------------------------------------------------------------
// Anchored literal matcher
// Matches a configured literal against a subject streamed at most one byte per beat.
//
//   Channel   Signals                               Direction  Beat
//   input     i_in_valid / o_in_ready + fields      in         up to one subject byte
//   output    o_out_valid / i_out_ready + fields    out        one result
//   config    i_cfg_we, i_cfg_idx, i_cfg_data       in         one register
//
// One input beat is taken every cycle unless input stalls; the result of the
// last byte is registered and shown the cycle after that beat is taken.
// The window compare runs over all cells in parallel in the accept cycle.
// Input stalls only while a result waits and i_out_ready is low.
// Reset is synchronous and clears configuration and control state.
// -----------------------------------------------------------------------------
module anchored_literal_matcher #(
    parameter int MAX_PATTERN = alm_pkg::MAX_PATTERN_DEF,
    parameter int MAX_SUBJECT = alm_pkg::MAX_SUBJECT_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  alm_pkg::t_cfg_idx             i_cfg_idx,
    input  logic [alm_pkg::CFG_W-1:0]     i_cfg_data,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [7:0]                    i_subject_byte,
    input  logic                          i_has_byte,
    input  logic [alm_pkg::POS_W-1:0]     i_start_pos,
    input  logic                          i_is_last,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic                          o_matched,
    output logic [alm_pkg::POS_W-1:0]     o_found_begin,
    output logic [alm_pkg::POS_W-1:0]     o_found_end,
    output logic                          o_too_long
);

    localparam int CNT_W = $clog2(MAX_SUBJECT + 2);
    localparam int LEN_W = $clog2(MAX_PATTERN + 1);
    localparam int WW    = alm_pkg::WORK_W;
    localparam int PW    = alm_pkg::POS_W;

    logic [alm_pkg::CFG_W-1:0]  r_pat [alm_pkg::PAT_REGS];
    logic [alm_pkg::PLEN_W-1:0] r_len;
    logic                       r_anc_s;
    logic                       r_anc_e;
    logic                       r_fold;

    logic             r_in_subject;
    logic [CNT_W-1:0] r_count;
    logic [PW-1:0]    r_start;
    logic             r_hit;
    logic [PW-1:0]    r_hit_off;
    logic             r_prefix;

    logic             r_out_valid;
    logic             r_matched;
    logic [PW-1:0]    r_fb;
    logic [PW-1:0]    r_fe;
    logic             r_tl;

    logic [7:0]       pat_b [alm_pkg::PAT_BYTES];
    logic [LEN_W-1:0] len_eff;
    logic             accept;

    logic [CNT_W-1:0] cnt0;
    logic [PW-1:0]    start0;
    logic             hit0;
    logic [PW-1:0]    hoff0;
    logic             pre0;
    logic             shift;

    logic [CNT_W-1:0] n_count;
    logic             n_hit;
    logic [PW-1:0]    n_hit_off;
    logic             n_prefix;
    logic             n_matched;
    logic [PW-1:0]    n_fb;
    logic [PW-1:0]    n_fe;
    logic             n_tl;

    logic [WW-1:0]    cnt_x;
    logic [WW-1:0]    len_x;
    logic [WW-1:0]    hit_s;
    logic             tail_ok;

    alm_pkg::t_cell_ctl cell_ctl;
    logic [7:0]       cell_data [MAX_PATTERN];
    logic [MAX_PATTERN-1:0] cell_ok;

    assign accept     = i_in_valid && o_in_ready;
    assign o_in_ready = !r_out_valid || i_out_ready;

    for (genvar j = 0; j < alm_pkg::PAT_BYTES; j++) begin : g_pat
        assign pat_b[j] = r_pat[j / 8][8 * (j % 8) +: 8];
    end

    assign len_eff = (r_len > alm_pkg::PLEN_W'(MAX_PATTERN)) ? LEN_W'(MAX_PATTERN)
                                                             : LEN_W'(r_len);

    always_comb begin
        cell_ctl.shift = accept && shift;
        cell_ctl.fold  = r_fold;
    end

    for (genvar k = 0; k < MAX_PATTERN; k++) begin : g_cell
        logic [alm_pkg::PLEN_W-1:0] pidx;
        logic [7:0]                 left;

        assign pidx = alm_pkg::PLEN_W'(len_eff) - alm_pkg::PLEN_W'(k + 1);
        if (k == 0) begin : g_head
            assign left = i_subject_byte;
        end else begin : g_body
            assign left = cell_data[k-1];
        end

        alm_cell u_cell (
            .i_clk    (i_clk),
            .i_ctl    (cell_ctl),
            .i_left   (left),
            .i_pat    (pat_b[pidx[alm_pkg::PIDX_W-1:0]]),
            .i_active (LEN_W'(k) < len_eff),
            .o_data   (cell_data[k]),
            .o_ok     (cell_ok[k])
        );
    end

    assign tail_ok = &cell_ok;

    always_comb begin
        cnt0   = r_in_subject ? r_count   : '0;
        start0 = r_in_subject ? r_start   : i_start_pos;
        hit0   = r_in_subject ? r_hit     : 1'b0;
        hoff0  = r_in_subject ? r_hit_off : '0;
        pre0   = r_in_subject ? r_prefix  : 1'b1;
        shift  = i_has_byte && (cnt0 < CNT_W'(MAX_SUBJECT));

        n_count   = cnt0;
        n_hit     = hit0;
        n_hit_off = hoff0;
        n_prefix  = pre0;
        len_x     = WW'(len_eff);
        hit_s     = '0;

        if (shift) begin
            if ((WW'(cnt0) < len_x) &&
                !alm_pkg::same_byte(i_subject_byte,
                                    pat_b[cnt0[alm_pkg::PIDX_W-1:0]], r_fold)) begin
                n_prefix = 1'b0;
            end
            n_count = cnt0 + CNT_W'(1);
            hit_s   = WW'(n_count) - len_x;
            if ((len_eff != '0) && !hit0 && (WW'(n_count) >= len_x) &&
                (hit_s >= WW'(start0)) && tail_ok) begin
                n_hit     = 1'b1;
                n_hit_off = hit_s[PW-1:0];
            end
        end else if (i_has_byte) begin
            n_count = CNT_W'(MAX_SUBJECT + 1);
        end

        cnt_x     = WW'(n_count);
        n_matched = 1'b0;
        n_fb      = '0;
        n_fe      = '0;
        n_tl      = 1'b0;
        priority if (cnt_x > WW'(MAX_SUBJECT)) begin
            n_tl = 1'b1;
        end else if (cnt_x >= len_x + WW'(start0)) begin
            priority if (r_anc_s) begin
                if ((start0 == '0) && !(r_anc_e && (cnt_x != len_x)) && n_prefix) begin
                    n_matched = 1'b1;
                    n_fe      = PW'(len_eff);
                end
            end else if (r_anc_e) begin
                if (tail_ok) begin
                    n_matched = 1'b1;
                    n_fb      = PW'(cnt_x - len_x);
                    n_fe      = cnt_x[PW-1:0];
                end
            end else if (len_eff == '0) begin
                n_matched = 1'b1;
                n_fb      = start0;
                n_fe      = start0;
            end else if (n_hit) begin
                n_matched = 1'b1;
                n_fb      = n_hit_off;
                n_fe      = n_hit_off + PW'(len_eff);
            end else begin
                n_matched = 1'b0;
            end
        end else begin
            n_tl = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < alm_pkg::PAT_REGS; i++) begin
                r_pat[i] <= '0;
            end
            r_len   <= '0;
            r_anc_s <= 1'b0;
            r_anc_e <= 1'b0;
            r_fold  <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                alm_pkg::CFG_PAT0:  r_pat[0] <= i_cfg_data;
                alm_pkg::CFG_PAT1:  r_pat[1] <= i_cfg_data;
                alm_pkg::CFG_PAT2:  r_pat[2] <= i_cfg_data;
                alm_pkg::CFG_PAT3:  r_pat[3] <= i_cfg_data;
                alm_pkg::CFG_LEN:   r_len    <= i_cfg_data[alm_pkg::PLEN_W-1:0];
                alm_pkg::CFG_ANC_S: r_anc_s  <= i_cfg_data[0];
                alm_pkg::CFG_ANC_E: r_anc_e  <= i_cfg_data[0];
                alm_pkg::CFG_FOLD:  r_fold   <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_subject <= 1'b0;
            r_count      <= '0;
            r_start      <= '0;
            r_hit        <= 1'b0;
            r_hit_off    <= '0;
            r_prefix     <= 1'b0;
        end else if (accept) begin
            r_in_subject <= !i_is_last;
            r_count      <= n_count;
            r_start      <= start0;
            r_hit        <= n_hit;
            r_hit_off    <= n_hit_off;
            r_prefix     <= n_prefix;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept && i_is_last) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && i_is_last) begin
            r_matched <= n_matched;
            r_fb      <= n_fb;
            r_fe      <= n_fe;
            r_tl      <= n_tl;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_matched     = r_matched;
    assign o_found_begin = r_fb;
    assign o_found_end   = r_fe;
    assign o_too_long    = r_tl;

endmodule

/* hw/rtl/alm_checker.sv */
// -----------------------------------------------------------------------------
// Anchored literal matcher checker
// Port-level checks on result beats, bound to the top level.
// -----------------------------------------------------------------------------
`include "anchored_literal_matcher_macros.svh"

module alm_checker (
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      i_in_valid,
    input logic                      o_in_ready,
    input logic                      i_is_last,
    input logic                      o_out_valid,
    input logic                      i_out_ready,
    input logic                      o_matched,
    input logic [alm_pkg::POS_W-1:0] o_found_begin,
    input logic [alm_pkg::POS_W-1:0] o_found_end,
    input logic                      o_too_long
);

    `ALM_ASSERT_NEXT(a_out_hold, o_out_valid && !i_out_ready, o_out_valid && $stable(o_matched) && $stable(o_found_begin) && $stable(o_found_end) && $stable(o_too_long), "result beat changed while stalled")
    `ALM_ASSERT_IMPL(a_long_no_match, o_out_valid && o_too_long, !o_matched, "overlong subject reported a match")
    `ALM_ASSERT_IMPL(a_miss_zero, o_out_valid && !o_matched, (o_found_begin == '0) && (o_found_end == '0), "miss carries nonzero offsets")
    `ALM_ASSERT_IMPL(a_result_cause, $rose(o_out_valid), $past(i_in_valid && o_in_ready && i_is_last), "result without a last input beat")

endmodule

bind anchored_literal_matcher alm_checker u_alm_checker (.*);

/* bench/tb_anchored_literal_matcher.sv */
// -----------------------------------------------------------------------------
// Anchored literal matcher testbench
// Streams directed and random subjects through the matcher under varying handshake
// pressure, predicts results in the bench or takes fixed verdicts for directed rows,
// and compares each output beat field by field against the oldest pending verdict.
// -----------------------------------------------------------------------------
module tb_anchored_literal_matcher;

    localparam int PAT_MAX     = alm_pkg::MAX_PATTERN_DEF;
    localparam int SUBJ_MAX    = alm_pkg::MAX_SUBJECT_DEF;
    localparam int POS_W       = alm_pkg::POS_W;
    localparam int CFG_W       = alm_pkg::CFG_W;
    localparam int PLEN_W      = alm_pkg::PLEN_W;
    localparam int HOLD_CYCLES = 400;
    localparam int CYCLE_LIMIT = 1_200_000;
    localparam int PHASE_BEATS = 650;
    localparam int PLAN_ROWS   = 30;

    typedef struct packed {
        logic [7:0]       data;
        logic             has;
        logic [POS_W-1:0] start;
        logic             last;
    } t_beat;

    typedef struct packed {
        logic             matched;
        logic [POS_W-1:0] found_begin;
        logic [POS_W-1:0] found_end;
        logic             too_long;
    } t_verdict;

    typedef enum logic [1:0] {ROW_CFG, ROW_BEAT, ROW_FIXED} t_row_kind;

    typedef struct packed {
        t_row_kind         kind;
        alm_pkg::t_cfg_idx idx;
        logic [CFG_W-1:0]  data;
        t_beat             beat;
        t_verdict          want;
    } t_plan_row;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              cfg_we = 1'b0;
    alm_pkg::t_cfg_idx cfg_idx = '0;
    logic [CFG_W-1:0]  cfg_data = '0;
    logic              in_valid = 1'b0;
    logic              in_ready;
    logic [7:0]        in_byte = '0;
    logic              in_has = 1'b0;
    logic [POS_W-1:0]  in_start = '0;
    logic              in_last = 1'b0;
    logic              out_valid;
    logic              out_ready = 1'b0;
    logic              o_matched;
    logic [POS_W-1:0]  o_found_begin;
    logic [POS_W-1:0]  o_found_end;
    logic              o_too_long;

    // Bench copy of the configuration and of the search state.
    logic [CFG_W-1:0]  pat_reg [4] = '{default: '0};
    logic [PLEN_W-1:0] pat_len_reg = '0;
    logic              anchor_s = 1'b0;
    logic              anchor_e = 1'b0;
    logic              fold_en = 1'b0;
    logic [7:0]        win [32] = '{default: 8'h00};
    int unsigned       seen_bytes = 0;
    logic [POS_W-1:0]  sub_start = '0;
    bit                hit_seen = 1'b0;
    int unsigned       hit_pos = 0;
    bit                prefix_good = 1'b0;
    bit                mid_subject = 1'b0;

    t_verdict    pending_verdicts [$];
    t_verdict    head;
    logic [7:0]  subject_q [$];
    int          mismatches = 0;
    int          cycle_count = 0;
    int unsigned beats_sent = 0;
    int unsigned tx_gap_pct = 0;
    int unsigned rx_stall_pct = 0;
    bit          hold_flip = 1'b0;
    bit          hold_seen = 1'b0;
    bit          cfg_open = 1'b0;

    t_plan_row plan [PLAN_ROWS] = '{
        '{ROW_FIXED, '0, '0, '{8'h00, 1'b0, 16'd0, 1'b1}, '{1'b1, 16'd0, 16'd0, 1'b0}},
        '{ROW_BEAT, '0, '0, '{8'hFF, 1'b1, 16'd5, 1'b0}, '0},
        '{ROW_FIXED, '0, '0, '{8'h00, 1'b1, 16'd0, 1'b1}, '0},
        '{ROW_CFG, alm_pkg::CFG_PAT0, 64'h0000_0000_0063_4261, '0, '0},
        '{ROW_CFG, alm_pkg::CFG_LEN, 64'd3, '0, '0},
        '{ROW_CFG, alm_pkg::CFG_FOLD, 64'd1, '0, '0},
        '{ROW_BEAT, '0, '0, '{8'h78, 1'b1, 16'd1, 1'b0}, '0},
        '{ROW_BEAT, '0, '0, '{8'h00, 1'b0, 16'hFFFF, 1'b0}, '0},
        '{ROW_BEAT, '0, '0, '{8'h41, 1'b1, 16'd0, 1'b0}, '0},
        '{ROW_BEAT, '0, '0, '{8'h62, 1'b1, 16'd0, 1'b0}, '0},
        '{ROW_BEAT, '0, '0, '{8'h43, 1'b1, 16'd0, 1'b1}, '0},
        '{ROW_CFG, alm_pkg::CFG_ANC_S, 64'd1, '0, '0},
        '{ROW_CFG, alm_pkg::CFG_FOLD, 64'd0, '0, '0},
        '{ROW_BEAT, '0, '0, '{8'h61, 1'b1, 16'd0, 1'b0}, '0},
        '{ROW_BEAT, '0, '0, '{8'h42, 1'b1, 16'd0, 1'b0}, '0},
        '{ROW_BEAT, '0, '0, '{8'h63, 1'b1, 16'd0, 1'b0}, '0},
        '{ROW_FIXED, '0, '0, '{8'h64, 1'b1, 16'd0, 1'b1}, '{1'b1, 16'd0, 16'd3, 1'b0}},
        '{ROW_CFG, alm_pkg::CFG_ANC_E, 64'd1, '0, '0},
        '{ROW_BEAT, '0, '0, '{8'h61, 1'b1, 16'd0, 1'b0}, '0},
        '{ROW_BEAT, '0, '0, '{8'h42, 1'b1, 16'd0, 1'b0}, '0},
        '{ROW_FIXED, '0, '0, '{8'h63, 1'b1, 16'd0, 1'b1}, '{1'b1, 16'd0, 16'd3, 1'b0}},
        '{ROW_CFG, alm_pkg::CFG_ANC_S, 64'd0, '0, '0},
        '{ROW_BEAT, '0, '0, '{8'h7A, 1'b1, 16'd0, 1'b0}, '0},
        '{ROW_BEAT, '0, '0, '{8'h61, 1'b1, 16'd0, 1'b0}, '0},
        '{ROW_BEAT, '0, '0, '{8'h42, 1'b1, 16'd0, 1'b0}, '0},
        '{ROW_BEAT, '0, '0, '{8'h63, 1'b1, 16'd0, 1'b1}, '0},
        '{ROW_CFG, alm_pkg::CFG_ANC_E, 64'd0, '0, '0},
        '{ROW_CFG, alm_pkg::CFG_LEN, 64'd63, '0, '0},
        '{ROW_CFG, alm_pkg::CFG_PAT3, 64'hFFFF_FFFF_FFFF_FFFF, '0, '0},
        '{ROW_FIXED, '0, '0, '{8'hFF, 1'b0, 16'hFFFF, 1'b1}, '0}
    };

    anchored_literal_matcher dut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_cfg_we       (cfg_we),
        .i_cfg_idx      (cfg_idx),
        .i_cfg_data     (cfg_data),
        .i_in_valid     (in_valid),
        .o_in_ready     (in_ready),
        .i_subject_byte (in_byte),
        .i_has_byte     (in_has),
        .i_start_pos    (in_start),
        .i_is_last      (in_last),
        .o_out_valid    (out_valid),
        .i_out_ready    (out_ready),
        .o_matched      (o_matched),
        .o_found_begin  (o_found_begin),
        .o_found_end    (o_found_end),
        .o_too_long     (o_too_long)
    );

    initial begin
        forever #6 clk = ~clk;
    end

    function automatic logic [7:0] to_lower(input logic [7:0] c);
        if (fold_en && c >= 8'h41 && c <= 8'h5A) begin
            return c + 8'h20;
        end
        return c;
    endfunction

    function automatic int unsigned used_len();
        return (pat_len_reg > PAT_MAX) ? PAT_MAX : pat_len_reg;
    endfunction

    function automatic logic [7:0] pat_at(input int unsigned j);
        return pat_reg[j / 8][(j % 8) * 8 +: 8];
    endfunction

    function automatic bit tail_equal(input int unsigned n);
        for (int unsigned j = 0; j < n; j++) begin
            if (to_lower(win[(n - 1 - j) % 32]) != to_lower(pat_at(j))) begin
                return 1'b0;
            end
        end
        return 1'b1;
    endfunction

    function automatic logic [7:0] pick_byte();
        int unsigned r = $urandom_range(19);
        if (r >= 16) begin
            return 8'($urandom);
        end
        return (r[0] ? 8'h41 : 8'h61) + 8'(r[1]);
    endfunction

    task automatic apply_reg(input alm_pkg::t_cfg_idx idx, input logic [CFG_W-1:0] word);
        case (idx)
            alm_pkg::CFG_PAT0, alm_pkg::CFG_PAT1,
            alm_pkg::CFG_PAT2, alm_pkg::CFG_PAT3: begin
                pat_reg[idx[1:0]] = word;
            end
            alm_pkg::CFG_LEN: pat_len_reg = word[PLEN_W-1:0];
            alm_pkg::CFG_ANC_S: anchor_s = word[0];
            alm_pkg::CFG_ANC_E: anchor_e = word[0];
            default: fold_en = word[0];
        endcase
    endtask

    // Advances the search state by one accepted beat and yields the result, if any.
    task automatic predict_search(input t_beat t, output bit produced, output t_verdict v);
        int unsigned len;
        int unsigned n;
        int unsigned s;
        len = used_len();
        produced = 1'b0;
        v = '0;
        if (!mid_subject) begin
            mid_subject = 1'b1;
            sub_start = t.start;
            seen_bytes = 0;
            hit_seen = 1'b0;
            hit_pos = 0;
            prefix_good = 1'b1;
        end
        if (t.has) begin
            if (seen_bytes < SUBJ_MAX) begin
                for (int k = 31; k > 0; k--) begin
                    win[k] = win[k-1];
                end
                win[0] = t.data;
                if (seen_bytes < len && to_lower(t.data) != to_lower(pat_at(seen_bytes))) begin
                    prefix_good = 1'b0;
                end
                seen_bytes++;
                if (len > 0 && !hit_seen && seen_bytes >= len) begin
                    s = seen_bytes - len;
                    if (s >= sub_start && tail_equal(len)) begin
                        hit_seen = 1'b1;
                        hit_pos = s;
                    end
                end
            end else begin
                seen_bytes = SUBJ_MAX + 1;
            end
        end
        if (t.last) begin
            produced = 1'b1;
            mid_subject = 1'b0;
            n = seen_bytes;
            if (n > SUBJ_MAX) begin
                v.too_long = 1'b1;
            end else if (n >= len + sub_start) begin
                if (anchor_s) begin
                    if (sub_start == 0 && !(anchor_e && n != len) && prefix_good) begin
                        v.matched = 1'b1;
                        v.found_end = POS_W'(len);
                    end
                end else if (anchor_e) begin
                    if (tail_equal(len)) begin
                        v.matched = 1'b1;
                        v.found_begin = POS_W'(n - len);
                        v.found_end = POS_W'(n);
                    end
                end else if (len == 0) begin
                    v.matched = 1'b1;
                    v.found_begin = sub_start;
                    v.found_end = sub_start;
                end else if (hit_seen) begin
                    v.matched = 1'b1;
                    v.found_begin = POS_W'(hit_pos);
                    v.found_end = POS_W'(hit_pos + len);
                end
            end
        end
    endtask

    task automatic flag_mismatch(input string what, input int got, input int want);
        $display("mismatch in %s at cycle %0d: dut %0d, predicted %0d",
                 what, cycle_count, got, want);
        mismatches++;
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        while (pending_verdicts.size() != 0) begin
            @(posedge clk);
        end
        repeat (3) @(posedge clk);
    endtask

    task automatic close_cfg();
        if (cfg_open) begin
            cfg_we <= 1'b0;
            cfg_open = 1'b0;
        end
    endtask

    task automatic put_reg(input alm_pkg::t_cfg_idx idx, input logic [CFG_W-1:0] word);
        if (!cfg_open) begin
            wait_idle();
            cfg_open = 1'b1;
        end
        cfg_we <= 1'b1;
        cfg_idx <= idx;
        cfg_data <= word;
        @(posedge clk);
        apply_reg(idx, word);
    endtask

    task automatic offer_beat(input t_beat t, input bit fixed, input t_verdict want);
        bit produced;
        t_verdict v;
        close_cfg();
        while (tx_gap_pct != 0 && $urandom_range(99) < tx_gap_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_byte <= t.data;
        in_has <= t.has;
        in_start <= t.start;
        in_last <= t.last;
        @(posedge clk);
        while (!in_ready) begin
            @(posedge clk);
        end
        predict_search(t, produced, v);
        if (produced) begin
            pending_verdicts.push_back(fixed ? want : v);
        end
        if (t.has || t.last) begin
            beats_sent++;
        end
    endtask

    task automatic send_subject(input logic [POS_W-1:0] start, input int unsigned gap_pct,
                                input bit tail_empty);
        t_beat t;
        bit first = 1'b1;
        if (subject_q.size() == 0) begin
            t = '{8'($urandom), 1'b0, start, 1'b1};
            offer_beat(t, 1'b0, '0);
            return;
        end
        foreach (subject_q[i]) begin
            if (gap_pct != 0 && $urandom_range(99) < gap_pct) begin
                t = '{8'($urandom), 1'b0, first ? start : POS_W'($urandom), 1'b0};
                offer_beat(t, 1'b0, '0);
                first = 1'b0;
            end
            t = '{subject_q[i], 1'b1, first ? start : POS_W'($urandom),
                  (i == subject_q.size() - 1) && !tail_empty};
            offer_beat(t, 1'b0, '0);
            first = 1'b0;
        end
        if (tail_empty) begin
            t = '{8'($urandom), 1'b0, POS_W'($urandom), 1'b1};
            offer_beat(t, 1'b0, '0);
        end
    endtask

    task automatic new_setting();
        logic [CFG_W-1:0] word;
        int unsigned r;
        for (int k = 0; k < alm_pkg::PAT_REGS; k++) begin
            for (int j = 0; j < 8; j++) begin
                word[j*8 +: 8] = pick_byte();
            end
            put_reg(alm_pkg::t_cfg_idx'(k), word);
        end
        r = $urandom_range(99);
        word = {$urandom, $urandom};
        if (r < 8) begin
            word[PLEN_W-1:0] = '0;
        end else if (r < 16) begin
            word[PLEN_W-1:0] = PLEN_W'(PAT_MAX);
        end else if (r < 22) begin
            word[PLEN_W-1:0] = PLEN_W'($urandom_range(33, 63));
        end else if (r < 30) begin
            word[PLEN_W-1:0] = PLEN_W'($urandom_range(7, 31));
        end else begin
            word[PLEN_W-1:0] = PLEN_W'($urandom_range(1, 6));
        end
        put_reg(alm_pkg::CFG_LEN, word);
        word = {$urandom, $urandom};
        word[0] = ($urandom_range(99) < 35);
        put_reg(alm_pkg::CFG_ANC_S, word);
        word = {$urandom, $urandom};
        word[0] = ($urandom_range(99) < 35);
        put_reg(alm_pkg::CFG_ANC_E, word);
        put_reg(alm_pkg::CFG_FOLD, {$urandom, $urandom});
    endtask

    // Builds a subject, often with the pattern planted at the front, the tail or
    // anywhere, with letters flipped in case when folding is on.
    task automatic build_subject(output logic [POS_W-1:0] start);
        int unsigned len;
        int unsigned n;
        int unsigned at;
        int unsigned r;
        logic [7:0] b;
        len = used_len();
        subject_q.delete();
        r = $urandom_range(99);
        if (r < 8) begin
            n = 0;
        end else if (r < 20) begin
            n = $urandom_range(0, len);
        end else begin
            n = len + $urandom_range(0, 10);
        end
        r = $urandom_range(99);
        if (r < 65) begin
            start = '0;
        end else if (r < 90) begin
            start = POS_W'($urandom_range(0, 3));
        end else begin
            start = POS_W'($urandom);
        end
        repeat (n) subject_q.push_back(pick_byte());
        if (len > 0 && n >= len && $urandom_range(99) < 65) begin
            r = $urandom_range(2);
            at = (r == 0) ? 0 : (r == 1) ? n - len : $urandom_range(0, n - len);
            for (int unsigned j = 0; j < len; j++) begin
                b = pat_at(j);
                if (fold_en && (b | 8'h20) >= 8'h61 && (b | 8'h20) <= 8'h7A &&
                    $urandom_range(1) == 1) begin
                    b = b ^ 8'h20;
                end
                subject_q[at + j] = b;
            end
        end
    endtask

    initial begin
        forever begin
            @(posedge clk);
            if (hold_flip != hold_seen) begin
                hold_seen = hold_flip;
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            out_ready <= (rx_stall_pct == 0) || ($urandom_range(99) >= rx_stall_pct);
        end
    end

    always @(posedge clk) begin
        if (rst_n && out_valid && out_ready) begin
            if (pending_verdicts.size() == 0) begin
                flag_mismatch("result beat with nothing pending", 1, 0);
            end else begin
                head = pending_verdicts.pop_front();
                if (o_matched !== head.matched) begin
                    flag_mismatch("matched", o_matched, head.matched);
                end
                if (o_found_begin !== head.found_begin) begin
                    flag_mismatch("found_begin", o_found_begin, head.found_begin);
                end
                if (o_found_end !== head.found_end) begin
                    flag_mismatch("found_end", o_found_end, head.found_end);
                end
                if (o_too_long !== head.too_long) begin
                    flag_mismatch("too_long", o_too_long, head.too_long);
                end
            end
        end
    end

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb_anchored_literal_matcher NOT OK");
            $finish;
        end
    end

    initial begin
        int unsigned left;
        int unsigned phase_end;
        logic [POS_W-1:0] st;
        left = 0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        foreach (plan[r]) begin
            case (plan[r].kind)
                ROW_CFG: put_reg(plan[r].idx, plan[r].data);
                ROW_BEAT: offer_beat(plan[r].beat, 1'b0, '0);
                default: offer_beat(plan[r].beat, 1'b1, plan[r].want);
            endcase
        end

        for (int ph = 0; ph < 3; ph++) begin
            tx_gap_pct = (ph == 0) ? 25 : (ph == 1) ? 54 : 0;
            rx_stall_pct <= (ph == 0) ? 54 : (ph == 1) ? 25 : 0;
            if (ph == 2) begin
                hold_flip <= ~hold_flip;
            end
            phase_end = beats_sent + PHASE_BEATS;
            while (beats_sent < phase_end) begin
                if (left == 0) begin
                    new_setting();
                    left = $urandom_range(1, 6);
                end
                build_subject(st);
                send_subject(st, ($urandom_range(3) == 0) ? 10 : 0, $urandom_range(19) == 0);
                left--;
            end
        end

        close_cfg();
        wait_idle();
        repeat (4) @(posedge clk);
        if (mismatches == 0) begin
            $display("tb_anchored_literal_matcher OK");
        end else begin
            $display("tb_anchored_literal_matcher NOT OK");
        end
        $finish;
    end

endmodule
